@@ hw/rtl/tccc_pkg.sv @@
package tccc_pkg;

	localparam int unsigned GLYPH_WIDTH  = 8;
	localparam int unsigned GLYPH_HEIGHT = 16;
	localparam int unsigned LINE_STEP    = 16;

	localparam int unsigned COORD_W = 12;
	// room for a coordinate plus a glyph step without overflow
	localparam int unsigned WIDE_W  = COORD_W + 2;

	localparam logic [COORD_W-1:0] SCREEN_WIDTH_RESET  = 12'd640;
	localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RESET = 12'd480;

	// configuration register indexes
	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	// request opcodes
	localparam logic OP_PUT_CHAR = 1'b0;
	localparam logic OP_CLEAR    = 1'b1;

	// renderer commands
	localparam logic [1:0] CMD_DRAW   = 2'd0;
	localparam logic [1:0] CMD_SCROLL = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
	localparam logic [7:0] CHAR_CR        = 8'd13;
	localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
	localparam logic [7:0] CHAR_DEL       = 8'd127;
	localparam logic [7:0] CHAR_SPACE     = 8'd32;

	typedef struct packed {
		logic       opcode;
		logic [7:0] char_code;
	} req_item_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [7:0]         glyph_code;
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic               last;
	} cmd_item_t;

	// commands produced by one request: count and up to two items, in order
	typedef struct packed {
		logic [1:0] count;
		cmd_item_t  first;
		cmd_item_t  second;
	} step_t;

endpackage

@@ hw/rtl/tccc_cursor.sv @@
module tccc_cursor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tccc_pkg::req_item_t             req_s1,
	input  logic                            advance,
	input  logic [tccc_pkg::COORD_W-1:0]    screen_width,
	input  logic [tccc_pkg::COORD_W-1:0]    screen_height,
	output tccc_pkg::step_t                 step
);

	localparam int unsigned CW = tccc_pkg::COORD_W;
	localparam int unsigned WW = tccc_pkg::WIDE_W;

	localparam logic [WW-1:0] GW_W = WW'(tccc_pkg::GLYPH_WIDTH);
	localparam logic [WW-1:0] GH_W = WW'(tccc_pkg::GLYPH_HEIGHT);
	localparam logic [WW-1:0] LS_W = WW'(tccc_pkg::LINE_STEP);
	localparam logic [CW-1:0] GW_C = CW'(tccc_pkg::GLYPH_WIDTH);
	localparam logic [CW-1:0] LS_C = CW'(tccc_pkg::LINE_STEP);

	logic [CW-1:0] col_q, row_q;
	logic [CW-1:0] col_next, row_next;

	logic [WW-1:0] col_w, row_w, width_w, height_w;
	logic [CW-1:0] bottom_row, right_col;
	logic          wrap;
	logic [WW-1:0] row_wrap;
	logic [WW-1:0] row_after_nl;
	logic          scroll_nl, scroll_pr;
	logic [CW-1:0] col_pr;
	logic [WW-1:0] row_pr;

	tccc_pkg::cmd_item_t draw_item, scroll_item;

	assign col_w    = WW'(col_q);
	assign row_w    = WW'(row_q);
	assign width_w  = WW'(screen_width);
	assign height_w = WW'(screen_height);

	// saturate the last line and last cell positions at zero on tiny screens
	assign bottom_row = (screen_height >= LS_C) ? screen_height - LS_C : '0;
	assign right_col  = (screen_width >= GW_C) ? screen_width - GW_C : '0;

	assign row_after_nl = row_w + LS_W;
	assign scroll_nl    = (row_after_nl + GH_W) > height_w;

	assign wrap     = (col_w + GW_W) > width_w;
	assign col_pr   = wrap ? '0 : col_q;
	assign row_wrap = wrap ? row_w + LS_W : row_w;
	assign scroll_pr = (row_wrap + GH_W) > height_w;
	assign row_pr   = scroll_pr ? WW'(bottom_row) : row_wrap;

	always_comb begin
		scroll_item            = '0;
		scroll_item.command    = tccc_pkg::CMD_SCROLL;
		scroll_item.last       = 1'b1;
		draw_item              = '0;
		draw_item.command      = tccc_pkg::CMD_DRAW;
		draw_item.last         = 1'b1;
		step                   = '0;
		col_next               = col_q;
		row_next               = row_q;
		if (req_s1.opcode == tccc_pkg::OP_CLEAR) begin
			step.count          = 2'd1;
			step.first          = '0;
			step.first.command  = tccc_pkg::CMD_CLEAR;
			step.first.last     = 1'b1;
			col_next            = '0;
			row_next            = '0;
		end else if (req_s1.char_code == tccc_pkg::CHAR_NEWLINE) begin
			col_next = '0;
			if (scroll_nl) begin
				step.count = 2'd1;
				step.first = scroll_item;
				row_next   = bottom_row;
			end else begin
				row_next = row_after_nl[CW-1:0];
			end
		end else if (req_s1.char_code == tccc_pkg::CHAR_CR) begin
			col_next = '0;
		end else if (req_s1.char_code == tccc_pkg::CHAR_BACKSPACE ||
				req_s1.char_code == tccc_pkg::CHAR_DEL) begin
			draw_item.glyph_code = tccc_pkg::CHAR_SPACE;
			if (col_q >= GW_C) begin
				col_next           = col_q - GW_C;
				draw_item.pixel_x  = col_q - GW_C;
				draw_item.pixel_y  = row_q;
				step.count         = 2'd1;
				step.first         = draw_item;
			end else if (row_q >= LS_C) begin
				col_next           = right_col;
				row_next           = row_q - LS_C;
				draw_item.pixel_x  = right_col;
				draw_item.pixel_y  = row_q - LS_C;
				step.count         = 2'd1;
				step.first         = draw_item;
			end
		end else if (req_s1.char_code >= tccc_pkg::CHAR_SPACE) begin
			draw_item.glyph_code = req_s1.char_code;
			draw_item.pixel_x    = col_pr;
			draw_item.pixel_y    = row_pr[CW-1:0];
			col_next             = col_pr + GW_C;
			row_next             = row_pr[CW-1:0];
			if (scroll_pr) begin
				scroll_item.last = 1'b0;
				step.count       = 2'd2;
				step.first       = scroll_item;
				step.second      = draw_item;
			end else begin
				step.count = 2'd1;
				step.first = draw_item;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			col_q <= col_next;
			row_q <= row_next;
		end
	end

endmodule

@@ hw/rtl/tccc_cmd_queue.sv @@
module tccc_cmd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tccc_pkg::step_t      step,
	input  logic                 push,
	output logic                 room,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output tccc_pkg::cmd_item_t  cmd_item
);

	tccc_pkg::cmd_item_t slot_q [2];
	tccc_pkg::cmd_item_t slot_next [2];
	logic [1:0] count_q, count_next, after_pop;
	logic       pop;

	assign pop       = cmd_valid && cmd_ready;
	assign cmd_valid = count_q != 2'd0;
	assign cmd_item  = slot_q[0];
	// free slots come from the registered count only
	assign room      = step.count <= (2'd2 - count_q);

	always_comb begin
		slot_next[0] = slot_q[0];
		slot_next[1] = slot_q[1];
		after_pop    = count_q;
		if (pop) begin
			slot_next[0] = slot_q[1];
			after_pop    = count_q - 2'd1;
		end
		count_next = after_pop;
		if (push) begin
			count_next = after_pop + step.count;
			if (step.count != 2'd0) begin
				slot_next[after_pop[0]] = step.first;
			end
			if (step.count == 2'd2) begin
				slot_next[1] = step.second;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		slot_q[0] <= slot_next[0];
		slot_q[1] <= slot_next[1];
	end

endmodule

@@ hw/rtl/text_console_cursor_control_unit.sv @@
// Text console cursor controller.
// Request channel (req_valid/req_ready/req_item): a character byte or a
// clear request. Command channel (cmd_valid/cmd_ready/cmd_item): draw
// glyph, scroll up one text line, or clear screen, for a renderer; the
// last flag marks the final command of a request.
// Configuration: cfg_write with cfg_index and cfg_data sets screen width
// (index 0) or height (index 1) in pixels; write only while idle.
// The first command of a request passes through the input register and
// then the command queue, whose head drives the command channel.
// Throughput: a request that yields one command is taken every cycle
// while the queue has room. A printable byte that also scrolls yields
// two commands, which enter the two-slot command queue only when it is
// empty; it drains one command per cycle while cmd_ready is high.
// Reset: cursor at top left, screen 640 by 480, no commands pending.
// When the renderer stalls, up to two commands wait in the queue and one
// request waits in the input register; req_ready then drops.
module text_console_cursor_control_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  tccc_pkg::req_item_t                 req_item,
	output logic                                cmd_valid,
	input  logic                                cmd_ready,
	output tccc_pkg::cmd_item_t                 cmd_item,
	input  logic                                cfg_write,
	input  logic                                cfg_index,
	input  logic [tccc_pkg::COORD_W-1:0]        cfg_data
);

	logic                         valid_s1;
	tccc_pkg::req_item_t          req_s1;
	logic                         advance;
	logic                         room;
	tccc_pkg::step_t              step;
	logic [tccc_pkg::COORD_W-1:0] screen_width_q, screen_height_q;

	assign advance   = valid_s1 && room;
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= tccc_pkg::SCREEN_WIDTH_RESET;
			screen_height_q <= tccc_pkg::SCREEN_HEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				tccc_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				tccc_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tccc_cursor u_cursor (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_s1        (req_s1),
		.advance       (advance),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.step          (step)
	);

	tccc_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.push      (advance),
		.room      (room),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_item  (cmd_item)
	);

`ifndef SYNTHESIS
	// scroll and clear carry no glyph or position
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_item.command != tccc_pkg::CMD_DRAW |->
		cmd_item.glyph_code == 8'd0 && cmd_item.pixel_x == '0 &&
		cmd_item.pixel_y == '0)
		else $error("scroll or clear with non-zero payload");

	// a scroll that is not last keeps cmd_valid asserted, as its draw is queued behind it
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_item.command == tccc_pkg::CMD_SCROLL && !cmd_item.last |=>
		cmd_valid)
		else $error("draw after scroll lost");

	// a clear is the only command of its request
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_item.command == tccc_pkg::CMD_CLEAR |-> cmd_item.last)
		else $error("clear not marked last");

	// a held request is not overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(req_s1))
		else $error("stalled request lost");
`endif

endmodule
